// ----- rtl/core/block_decomposed_range_add_sum_assert.svh -----
// Assertion macros shared by the checker of the range add and sum store.
`ifndef BLOCK_DECOMPOSED_RANGE_ADD_SUM_ASSERT_SVH
`define BLOCK_DECOMPOSED_RANGE_ADD_SUM_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BDRS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BDRS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/bdrs_pkg.sv -----
`timescale 1ns / 1ps

package bdrs_pkg;

   // Capacity of the store.
   localparam int MAX_ELEMENTS = 1024;
   localparam int MAX_BLOCKS   = 64;

   // Internal segmentation of the element store: fixed power-of-two segments.
   localparam int ELEM_AW  = $clog2(MAX_ELEMENTS);
   localparam int SEG_AW   = 5;
   localparam int NUM_SEGS = MAX_ELEMENTS >> SEG_AW;
   localparam int SEG_NW   = ELEM_AW - SEG_AW;

   // Field widths.
   localparam int IDX_W     = 11;
   localparam int VALUE_W   = 32;
   localparam int SUM_W     = 64;
   localparam int STATUS_W  = 2;
   localparam int LAYOUT_W  = IDX_W + $clog2(MAX_BLOCKS);

   // Configuration port.
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   // Request codes.
   localparam logic REQ_ADD   = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Register indexes.
   localparam logic REG_COUNT = 1'b0;
   localparam logic REG_BLEN  = 1'b1;

   // Register reset values.
   localparam logic [IDX_W-1:0] COUNT_RESET = IDX_W'(1024);
   localparam logic [IDX_W-1:0] BLEN_RESET  = IDX_W'(32);

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_RANGE  = 2'd1,
      STAT_BLOCKS = 2'd2
   } bdrs_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEG_RD,
      ST_SEG_USE,
      ST_ELEM,
      ST_SEG_FIN,
      ST_DONE
   } bdrs_state_type;

endpackage

// ----- rtl/core/bdrs_req_if.sv -----
`timescale 1ns / 1ps

interface bdrs_req_if import bdrs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic [IDX_W-1:0]          left;
   logic [IDX_W-1:0]          right;
   logic signed [VALUE_W-1:0] value;

   modport source(output valid, req_type, left, right, value, input ready);
   modport sink(input valid, req_type, left, right, value, output ready);
endinterface

// ----- rtl/core/bdrs_rsp_if.sv -----
`timescale 1ns / 1ps

interface bdrs_rsp_if import bdrs_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [SUM_W-1:0]   sum;
   logic [STATUS_W-1:0]       status;

   modport source(output valid, sum, status, input ready);
   modport sink(input valid, sum, status, output ready);
endinterface

// ----- rtl/core/bdrs_ram.sv -----
`timescale 1ns / 1ps

module bdrs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/block_decomposed_range_add_sum.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Contents
// req_ch    in         req_type, left, right, value
// rsp_ch    out        sum, status
// csr       in/out     APB-style register port (element_count, block_len)
//
// An item's time grows with the whole 32-element segments in its range and
// with each element of a partly covered end segment; it is set by the single
// read port of the element memory. Rejected items skip the memories.
// After reset a clearing pass zeroes the memories; no transaction is accepted
// meanwhile. The result register frees the engine from a stalled result side
// until the next result is due.

module block_decomposed_range_add_sum import bdrs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   bdrs_req_if.sink           req_ch,
   bdrs_rsp_if.source         rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [CSR_AW-1:0]  paddr,
   input  logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]  prdata,
   output logic               pready
);

   bdrs_state_type state_ff, state_in;

   logic [ELEM_AW-1:0]  clr_ff, clr_in;
   logic [IDX_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    blen_ff, blen_in;
   logic                query_ff, query_in;
   logic [ELEM_AW-1:0]  lo_ff, lo_in;
   logic [ELEM_AW-1:0]  hi_ff, hi_in;
   logic [SUM_W-1:0]    vext_ff, vext_in;
   logic [SEG_NW-1:0]   seg_ff, seg_in;
   logic [SUM_W-1:0]    lz_ff, lz_in;
   logic [SUM_W-1:0]    bs_ff, bs_in;
   logic [ELEM_AW-1:0]  ei_ff, ei_in;
   logic [ELEM_AW-1:0]  eend_ff, eend_in;
   logic                issue_ff, issue_in;
   logic                pv_ff, pv_in;
   logic [ELEM_AW-1:0]  pa_ff, pa_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   bdrs_status_type     status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;
   bdrs_status_type     rsp_status_ff, rsp_status_in;

   // Memory ports.
   logic                em_we, em_re;
   logic [ELEM_AW-1:0]  em_waddr, em_raddr;
   logic [SUM_W-1:0]    em_wdata, em_rdata;
   logic                sm_we, sm_re;
   logic [SEG_NW-1:0]   sm_waddr, sm_raddr;
   logic [2*SUM_W-1:0]  sm_wdata, sm_rdata;

   logic                req_accept;
   logic                csr_write;
   logic [IDX_W-1:0]    n_eff;
   logic [LAYOUT_W-1:0] layout_cap;
   logic                layout_bad, range_bad;
   logic [ELEM_AW-1:0]  seg_base, seg_top, s_lo, s_hi;
   logic                s_full, seg_last;
   logic [SUM_W-1:0]    rd_lz, rd_bs;

   // Element values (without the segment's pending add).
   bdrs_ram #(.WIDTH(SUM_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
      .clock(clock), .wr_en(em_we), .wr_addr(em_waddr), .wr_data(em_wdata),
      .rd_en(em_re), .rd_addr(em_raddr), .rd_data(em_rdata)
   );

   // Per segment: pending add in the upper half, full segment sum in the lower.
   bdrs_ram #(.WIDTH(2*SUM_W), .DEPTH(NUM_SEGS)) u_seg_ram (
      .clock(clock), .wr_en(sm_we), .wr_addr(sm_waddr), .wr_data(sm_wdata),
      .rd_en(sm_re), .rd_addr(sm_raddr), .rd_data(sm_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.sum    = rsp_sum_ff;
   assign rsp_ch.status = rsp_status_ff;

   // Register port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      count_in = count_ff;
      blen_in  = blen_ff;
      prdata   = '0;
      case (paddr[CSR_AW-1])
         REG_COUNT: begin
            prdata = CSR_DW'(count_ff);
            if (csr_write) begin
               count_in = pwdata[IDX_W-1:0];
            end
         end
         REG_BLEN: begin
            prdata = CSR_DW'(blen_ff);
            if (csr_write) begin
               blen_in = pwdata[IDX_W-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   // Request checks: the block count limit first, then the range.
   assign n_eff      = (count_ff > IDX_W'(MAX_ELEMENTS)) ? IDX_W'(MAX_ELEMENTS) : count_ff;
   assign layout_cap = LAYOUT_W'(blen_ff) * LAYOUT_W'(MAX_BLOCKS);
   assign layout_bad = (blen_ff == '0) || (LAYOUT_W'(n_eff) > layout_cap);
   assign range_bad  = (req_ch.left == '0) || (req_ch.right < req_ch.left)
                    || (req_ch.right > n_eff);

   // Bounds of the current segment clipped to the range.
   assign seg_base = {seg_ff, {SEG_AW{1'b0}}};
   assign seg_top  = {seg_ff, {SEG_AW{1'b1}}};
   assign s_lo     = (seg_ff == lo_ff[ELEM_AW-1:SEG_AW]) ? lo_ff : seg_base;
   assign s_hi     = (seg_ff == hi_ff[ELEM_AW-1:SEG_AW]) ? hi_ff : seg_top;
   assign s_full   = (s_lo == seg_base) && (s_hi == seg_top);
   assign seg_last = (seg_ff == hi_ff[ELEM_AW-1:SEG_AW]);
   assign rd_lz    = sm_rdata[2*SUM_W-1:SUM_W];
   assign rd_bs    = sm_rdata[SUM_W-1:0];

   // Sequencer: next state, datapath and memory accesses.
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      query_in      = query_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      vext_in       = vext_ff;
      seg_in        = seg_ff;
      lz_in         = lz_ff;
      bs_in         = bs_ff;
      ei_in         = ei_ff;
      eend_in       = eend_ff;
      issue_in      = issue_ff;
      pv_in         = 1'b0;
      pa_in         = ei_ff;
      acc_in        = acc_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      em_we         = 1'b0;
      em_waddr      = pa_ff;
      em_wdata      = em_rdata + vext_ff;
      em_re         = 1'b0;
      em_raddr      = ei_ff;
      sm_we         = 1'b0;
      sm_waddr      = seg_ff;
      sm_wdata      = {lz_ff, bs_ff};
      sm_re         = 1'b0;
      sm_raddr      = seg_ff;

      case (state_ff)
         ST_CLEAR: begin
            em_we    = 1'b1;
            em_waddr = clr_ff;
            em_wdata = '0;
            sm_we    = 1'b1;
            sm_waddr = clr_ff[SEG_NW-1:0];
            sm_wdata = '0;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == ELEM_AW'(MAX_ELEMENTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               query_in = (req_ch.req_type == REQ_QUERY);
               lo_in    = ELEM_AW'(req_ch.left - 1'b1);
               hi_in    = ELEM_AW'(req_ch.right - 1'b1);
               vext_in  = SUM_W'(req_ch.value);
               seg_in   = lo_in[ELEM_AW-1:SEG_AW];
               acc_in   = '0;
               if (layout_bad) begin
                  status_in = STAT_BLOCKS;
                  state_in  = ST_DONE;
               end else if (range_bad) begin
                  status_in = STAT_RANGE;
                  state_in  = ST_DONE;
               end else begin
                  status_in = STAT_OK;
                  state_in  = ST_SEG_RD;
               end
            end
         end
         ST_SEG_RD: begin
            sm_re    = 1'b1;
            state_in = ST_SEG_USE;
         end
         ST_SEG_USE: begin
            lz_in = rd_lz;
            bs_in = rd_bs;
            if (s_full) begin
               // A whole segment takes the add as pending, or gives its sum.
               if (query_ff) begin
                  acc_in = acc_ff + rd_bs;
               end else begin
                  sm_we    = 1'b1;
                  sm_wdata = {rd_lz + vext_ff, rd_bs + (vext_ff << SEG_AW)};
               end
               if (seg_last) begin
                  state_in = ST_DONE;
               end else begin
                  seg_in   = seg_ff + 1'b1;
                  state_in = ST_SEG_RD;
               end
            end else begin
               ei_in    = s_lo;
               eend_in  = s_hi;
               issue_in = 1'b1;
               state_in = ST_ELEM;
            end
         end
         ST_ELEM: begin
            // Stream the partial segment: read one element, use the previous one.
            em_re = issue_ff;
            pv_in = issue_ff;
            if (issue_ff) begin
               if (ei_ff == eend_ff) begin
                  issue_in = 1'b0;
               end else begin
                  ei_in = ei_ff + 1'b1;
               end
            end
            if (pv_ff) begin
               if (query_ff) begin
                  acc_in = acc_ff + em_rdata + lz_ff;
               end else begin
                  em_we = 1'b1;
                  bs_in = bs_ff + vext_ff;
               end
            end
            if (!issue_ff && !pv_ff) begin
               state_in = ST_SEG_FIN;
            end
         end
         ST_SEG_FIN: begin
            sm_we = !query_ff;
            if (seg_last) begin
               state_in = ST_DONE;
            end else begin
               seg_in   = seg_ff + 1'b1;
               state_in = ST_SEG_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sum_in    = acc_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= COUNT_RESET;
         blen_ff      <= BLEN_RESET;
         issue_ff     <= 1'b0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         blen_ff      <= blen_in;
         issue_ff     <= issue_in;
         pv_ff        <= pv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      query_ff      <= query_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      vext_ff       <= vext_in;
      seg_ff        <= seg_in;
      lz_ff         <= lz_in;
      bs_ff         <= bs_in;
      ei_ff         <= ei_in;
      eend_ff       <= eend_in;
      pa_ff         <= pa_in;
      acc_ff        <= acc_in;
      status_ff     <= status_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ----- rtl/core/bdrs_checker.sv -----
`timescale 1ns / 1ps
`include "block_decomposed_range_add_sum_assert.svh"

module bdrs_checker import bdrs_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SUM_W-1:0]    rsp_sum,
   input logic [STATUS_W-1:0] rsp_status
);

   // A rejected transaction carries a zero sum.
   `BDRS_ASSERT_NOW(a_err_sum_zero, clock, reset, rsp_valid && (rsp_status != STAT_OK), rsp_sum == '0, "non-zero sum with error status")

   // The clearing pass keeps the request side closed right after reset.
   `BDRS_ASSERT_NOW(a_clear_busy, clock, reset, $fell(reset), !req_ready, "request accepted during clearing")

   // One transaction at a time: the block is busy after an accept.
   `BDRS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "ready straight after accept")

   // A stalled result holds.
   `BDRS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sum) && $stable(rsp_status), "stalled result changed")

endmodule

bind block_decomposed_range_add_sum bdrs_checker u_bdrs_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_ch.valid),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .rsp_sum(rsp_ch.sum),
   .rsp_status(rsp_ch.status)
);
